// ----- rtl/snmf_pkg.sv -----
`default_nettype none
package snmf_pkg;

   localparam int MAX_LEN     = 65536;
   localparam int MAX_PATTERN = 8;
   localparam int MAX_NTH     = 16;

   localparam int BYTE_W    = 8;
   localparam int PAT_W     = 64;
   localparam int PAT_LEN_W = 4;
   localparam int OCC_W     = 6;
   localparam int IDX_W     = 16;
   localparam int COUNT_W   = 17;

   localparam int WIN_W    = BYTE_W * MAX_PATTERN;
   localparam int WIN_AW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LEN_W    = $clog2(MAX_PATTERN + 1);
   localparam int POS_W    = $clog2(MAX_LEN) + 1;
   localparam int START_W  = $clog2(MAX_LEN);
   localparam int RING_AW  = (MAX_NTH > 1) ? $clog2(MAX_NTH) : 1;
   localparam int NTH_W    = ($clog2(MAX_NTH + 1) + 1 > OCC_W) ?
                             $clog2(MAX_NTH + 1) + 1 : OCC_W;

   localparam int CSR_DW = 64;
   localparam int CSR_AW = 5;

   typedef enum logic [1:0] {
      REG_PATTERN_BYTES  = 2'd0,
      REG_PATTERN_LENGTH = 2'd1,
      REG_OCCURRENCE     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [PAT_W-1:0] pattern;
      logic [LEN_W-1:0] length;
      logic [OCC_W-1:0] occurrence;
   } cfg_type;

   typedef struct packed {
      logic               found;
      logic [IDX_W-1:0]   match_index;
      logic [COUNT_W-1:0] match_count;
      logic               overflow;
   } result_type;

endpackage
`default_nettype wire

// ----- rtl/snmf_match.sv -----
`default_nettype none
module snmf_match (
   input  wire logic [snmf_pkg::WIN_W-1:0]  window,
   input  wire logic [snmf_pkg::BYTE_W-1:0] text_byte,
   input  wire logic [snmf_pkg::PAT_W-1:0]  pattern,
   input  wire logic [snmf_pkg::LEN_W-1:0]  length,
   output logic      [snmf_pkg::WIN_W-1:0]  window_next,
   output logic                             window_hit
);

   logic [snmf_pkg::WIN_AW-1:0] tap;

   // newest byte sits in the lowest lane, pattern byte 0 pairs with the oldest lane in use
   always_comb begin
      window_next = {window[snmf_pkg::WIN_W-snmf_pkg::BYTE_W-1:0], text_byte};
      window_hit  = 1'b1;
      tap         = '0;
      for (int j = 0; j < snmf_pkg::MAX_PATTERN; j++) begin
         if (snmf_pkg::LEN_W'(j) < length) begin
            tap = snmf_pkg::WIN_AW'(length - snmf_pkg::LEN_W'(j) - snmf_pkg::LEN_W'(1));
            if (window_next[snmf_pkg::BYTE_W*tap +: snmf_pkg::BYTE_W] !=
                pattern[snmf_pkg::BYTE_W*j +: snmf_pkg::BYTE_W]) begin
               window_hit = 1'b0;
            end
         end
      end
   end

endmodule
`default_nettype wire

// ----- rtl/snmf_tracker.sv -----
`default_nettype none
module snmf_tracker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             step,
   input  wire logic [snmf_pkg::BYTE_W-1:0]      text_byte,
   input  wire logic                             last_byte,
   input  wire snmf_pkg::cfg_type                cfg,
   output snmf_pkg::result_type                  result
);

   logic [snmf_pkg::WIN_W-1:0]   window_ff, window_in, window_next;
   logic [snmf_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [snmf_pkg::POS_W-1:0]   hits_ff, hits_in;
   logic                         lfound_ff, lfound_in;
   logic [snmf_pkg::START_W-1:0] lstart_ff, lstart_in;
   logic [snmf_pkg::RING_AW-1:0] head_ff, head_in;
   logic [snmf_pkg::POS_W-1:0]   nonov_ff, nonov_in;
   logic [snmf_pkg::POS_W-1:0]   next_start_ff, next_start_in;
   logic                         ovf_ff, ovf_in;
   logic [snmf_pkg::START_W-1:0] ring_ff [snmf_pkg::MAX_NTH];

   logic                         window_hit;
   logic                         live;
   logic                         hit;
   logic [snmf_pkg::POS_W-1:0]   pos_plus;
   logic [snmf_pkg::POS_W-1:0]   start;
   logic [snmf_pkg::POS_W-1:0]   hits_next;
   logic [snmf_pkg::OCC_W-2:0]   target;
   logic                         occ_neg;
   logic [snmf_pkg::OCC_W-1:0]   nth;
   logic [snmf_pkg::RING_AW-1:0] head_next;
   logic [snmf_pkg::NTH_W-1:0]   rd_sum;
   logic [snmf_pkg::RING_AW-1:0] rd_addr;
   logic                         nth_ok;
   logic [snmf_pkg::START_W-1:0] right_start;

   snmf_match u_match (
      .window      (window_ff),
      .text_byte   (text_byte),
      .pattern     (cfg.pattern),
      .length      (cfg.length),
      .window_next (window_next),
      .window_hit  (window_hit)
   );

   always_comb begin
      live      = pos_ff < snmf_pkg::POS_W'(snmf_pkg::MAX_LEN);
      pos_plus  = pos_ff + snmf_pkg::POS_W'(1);
      start     = pos_plus - snmf_pkg::POS_W'(cfg.length);
      hit       = live && (cfg.length != '0) &&
                  (pos_plus >= snmf_pkg::POS_W'(cfg.length)) && window_hit;
      hits_next = hit ? hits_ff + snmf_pkg::POS_W'(1) : hits_ff;
      occ_neg   = cfg.occurrence[snmf_pkg::OCC_W-1];
      target    = (cfg.occurrence == '0) ? (snmf_pkg::OCC_W-1)'(1) :
                  cfg.occurrence[snmf_pkg::OCC_W-2:0];
      if (!hit) begin
         head_next = head_ff;
      end else if (head_ff == snmf_pkg::RING_AW'(snmf_pkg::MAX_NTH - 1)) begin
         head_next = '0;
      end else begin
         head_next = head_ff + snmf_pkg::RING_AW'(1);
      end

      // right-hand lookup: n back from the slot after the newest entry
      nth    = ~cfg.occurrence + snmf_pkg::OCC_W'(1);
      nth_ok = (snmf_pkg::NTH_W'(nth) <= snmf_pkg::NTH_W'(snmf_pkg::MAX_NTH)) &&
               (snmf_pkg::POS_W'(nth) <= hits_next);
      rd_sum = snmf_pkg::NTH_W'(head_next) + snmf_pkg::NTH_W'(snmf_pkg::MAX_NTH) -
               snmf_pkg::NTH_W'(nth);
      if (rd_sum >= snmf_pkg::NTH_W'(snmf_pkg::MAX_NTH)) begin
         rd_sum = rd_sum - snmf_pkg::NTH_W'(snmf_pkg::MAX_NTH);
      end
      rd_addr = snmf_pkg::RING_AW'(rd_sum);
      if (hit && nth == snmf_pkg::OCC_W'(1)) begin
         right_start = snmf_pkg::START_W'(start);
      end else begin
         right_start = ring_ff[rd_addr];
      end

      window_in     = live ? window_next : window_ff;
      pos_in        = live ? pos_plus : pos_ff;
      hits_in       = hits_next;
      head_in       = head_next;
      ovf_in        = ovf_ff || !live;
      lfound_in     = lfound_ff;
      lstart_in     = lstart_ff;
      nonov_in      = nonov_ff;
      next_start_in = next_start_ff;
      if (hit && !occ_neg && !lfound_ff &&
          hits_next == snmf_pkg::POS_W'(target)) begin
         lfound_in = 1'b1;
         lstart_in = snmf_pkg::START_W'(start);
      end
      if (hit && start >= next_start_ff) begin
         nonov_in      = nonov_ff + snmf_pkg::POS_W'(1);
         next_start_in = start + snmf_pkg::POS_W'(cfg.length);
      end

      result.found       = occ_neg ? nth_ok : lfound_in;
      result.match_index = '0;
      if (occ_neg && nth_ok) begin
         result.match_index = snmf_pkg::IDX_W'(right_start);
      end else if (!occ_neg && lfound_in) begin
         result.match_index = snmf_pkg::IDX_W'(lstart_in);
      end
      result.match_count = snmf_pkg::COUNT_W'(nonov_in);
      result.overflow    = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         window_ff     <= '0;
         pos_ff        <= '0;
         hits_ff       <= '0;
         lfound_ff     <= 1'b0;
         lstart_ff     <= '0;
         head_ff       <= '0;
         nonov_ff      <= '0;
         next_start_ff <= '0;
         ovf_ff        <= 1'b0;
      end else if (step) begin
         window_ff     <= window_in;
         pos_ff        <= pos_in;
         hits_ff       <= hits_in;
         lfound_ff     <= lfound_in;
         lstart_ff     <= lstart_in;
         head_ff       <= head_in;
         nonov_ff      <= nonov_in;
         next_start_ff <= next_start_in;
         ovf_ff        <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && hit) begin
         ring_ff[head_ff] <= snmf_pkg::START_W'(start);
      end
   end

endmodule
`default_nettype wire

// ----- rtl/substring_nth_match_finder.sv -----
`default_nettype none
// channel   direction  ports                                            handshake
// req       in         req_text_byte, req_last_byte                     req_valid / req_ready
// rsp       out        rsp_found, rsp_match_index, rsp_match_count,     rsp_valid / rsp_ready
//                      rsp_overflow
// csr       in/out     psel, penable, pwrite, paddr, pwdata, prdata     pready always high
//
// one text word per cycle while req_ready is high; the compare and counter update sit between the scan
// state and the result register, so a result shows in the cycle after its last word
// reset is synchronous and clears scan state and the result register, no clearing pass
// req_ready drops only while a finished result is held by a low rsp_ready
module substring_nth_match_finder (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [snmf_pkg::BYTE_W-1:0]       req_text_byte,
   input  wire logic                              req_last_byte,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_found,
   output logic      [snmf_pkg::IDX_W-1:0]        rsp_match_index,
   output logic      [snmf_pkg::COUNT_W-1:0]      rsp_match_count,
   output logic                                   rsp_overflow,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [snmf_pkg::CSR_AW-1:0]       paddr,
   input  wire logic [snmf_pkg::CSR_DW-1:0]       pwdata,
   output logic      [snmf_pkg::CSR_DW-1:0]       prdata,
   output logic                                   pready
);

   logic [snmf_pkg::PAT_W-1:0]     pattern_ff, pattern_in;
   logic [snmf_pkg::PAT_LEN_W-1:0] plen_ff, plen_in;
   logic [snmf_pkg::OCC_W-1:0]     occ_ff, occ_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   snmf_pkg::result_type           rsp_ff;
   snmf_pkg::result_type           result;
   snmf_pkg::cfg_type              cfg;
   snmf_pkg::csr_index_type        csr_index;
   logic                           csr_write;
   logic                           step;

   assign pready    = 1'b1;
   assign csr_index = snmf_pkg::csr_index_type'(paddr[snmf_pkg::CSR_AW-1:3]);
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      pattern_in = pattern_ff;
      plen_in    = plen_ff;
      occ_in     = occ_ff;
      prdata     = '0;
      case (csr_index)
         snmf_pkg::REG_PATTERN_BYTES: begin
            prdata = pattern_ff;
            if (csr_write) pattern_in = pwdata;
         end
         snmf_pkg::REG_PATTERN_LENGTH: begin
            prdata = snmf_pkg::CSR_DW'(plen_ff);
            if (csr_write) plen_in = pwdata[snmf_pkg::PAT_LEN_W-1:0];
         end
         snmf_pkg::REG_OCCURRENCE: begin
            prdata = snmf_pkg::CSR_DW'(occ_ff);
            if (csr_write) occ_in = pwdata[snmf_pkg::OCC_W-1:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         plen_ff    <= snmf_pkg::PAT_LEN_W'(1);
         occ_ff     <= snmf_pkg::OCC_W'(1);
      end else begin
         pattern_ff <= pattern_in;
         plen_ff    <= plen_in;
         occ_ff     <= occ_in;
      end
   end

   // pattern length saturates at the window size
   always_comb begin
      cfg.pattern    = pattern_ff;
      cfg.occurrence = occ_ff;
      if (plen_ff > snmf_pkg::PAT_LEN_W'(snmf_pkg::MAX_PATTERN)) begin
         cfg.length = snmf_pkg::LEN_W'(snmf_pkg::MAX_PATTERN);
      end else begin
         cfg.length = snmf_pkg::LEN_W'(plen_ff);
      end
   end

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   snmf_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .text_byte (req_text_byte),
      .last_byte (req_last_byte),
      .cfg       (cfg),
      .result    (result)
   );

   always_comb begin
      if (step && req_last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff <= '0;
      end else if (step && req_last_byte) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_ff.found;
   assign rsp_match_index = rsp_ff.match_index;
   assign rsp_match_count = rsp_ff.match_count;
   assign rsp_overflow    = rsp_ff.overflow;

endmodule
`default_nettype wire

// ----- rtl/snmf_checker.sv -----
`default_nettype none
module snmf_port_checks (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic [snmf_pkg::BYTE_W-1:0]       req_text_byte,
   input wire logic                              req_last_byte,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic                              rsp_found,
   input wire logic [snmf_pkg::IDX_W-1:0]        rsp_match_index,
   input wire logic [snmf_pkg::COUNT_W-1:0]      rsp_match_count,
   input wire logic                              rsp_overflow,
   input wire logic                              psel,
   input wire logic                              penable,
   input wire logic                              pwrite,
   input wire logic [snmf_pkg::CSR_AW-1:0]       paddr,
   input wire logic [snmf_pkg::CSR_DW-1:0]       pwdata,
   input wire logic [snmf_pkg::CSR_DW-1:0]       prdata,
   input wire logic                              pready
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_match_index) && $stable(rsp_match_count) && $stable(rsp_overflow))
      else $error("result word changed while stalled");

   // last word yields a result next cycle
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_byte |=> rsp_valid)
      else $error("no result after last word");

   // input stalls only behind a held result
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input stalled without a held result");

   // not found reports index zero
   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_index == '0)
      else $error("nonzero index on a miss");

endmodule

bind substring_nth_match_finder snmf_port_checks u_snmf_port_checks (.*);
`default_nettype wire
